/* rtl/hkce_pkg.sv */
// Package for the Hermite keyframe curve evaluator: payload structs, register
// indexes, controller states and the command/status structs between modules.
// No dependencies.
package hkce_pkg;

	localparam int MAX_KEYS   = 8;
	localparam int FRAC_BITS  = 16;
	localparam int KEY_W      = $clog2(MAX_KEYS);
	localparam int CNT_W      = 4;
	localparam int DEPTH      = 3 * MAX_KEYS;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam logic [16:0] ONE_Q = 17'(1 << FRAC_BITS);

	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_MULT   = 3'd1;
	localparam logic [2:0] REG_CONST  = 3'd2;
	localparam logic [2:0] REG_CLOW   = 3'd3;
	localparam logic [2:0] REG_CHIGH  = 3'd4;
	localparam logic [2:0] REG_NMAIN  = 3'd5;
	localparam logic [2:0] REG_NLOW   = 3'd6;
	localparam logic [2:0] REG_NHIGH  = 3'd7;

	localparam logic [2:0] MODE_CONST  = 3'd0;
	localparam logic [2:0] MODE_CURVE  = 3'd1;
	localparam logic [2:0] MODE_TWOC   = 3'd2;
	localparam logic [2:0] MODE_TWOCV  = 3'd3;
	localparam logic [2:0] MODE_RCONST = 3'd4;
	localparam logic [2:0] MODE_RCURVE = 3'd5;

	localparam logic CMD_EVAL = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [16:0]        sample_time;
		logic [16:0]        random_weight;
		logic [1:0]         curve_slot;
		logic [2:0]         key_index;
		logic [16:0]        key_time;
		logic signed [31:0] key_value;
		logic signed [31:0] tangent_in;
		logic signed [31:0] tangent_out;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] curve_result;
		logic               saturated;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CURVE, ST_RD, ST_CHK, ST_SRCH, ST_SEG, ST_DIV,
		ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_SUM,
		ST_CDONE, ST_BL1, ST_BL2, ST_SC1, ST_SC2, ST_OUT
	} state_t;

	// datapath micro-operation selected by the controller
	typedef enum logic [4:0] {
		OP_NONE, OP_LATCH, OP_CURVE, OP_RD, OP_CHK, OP_SRCH, OP_SEG, OP_DIV,
		OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6, OP_M7, OP_M8, OP_SUM,
		OP_CDONE, OP_BL1, OP_BL2, OP_SC1, OP_SC2
	} op_t;

	typedef struct packed {
		op_t  op;
		logic slot_hi;   // evaluating maximum curve
	} dp_cmd_t;

	typedef struct packed {
		logic is_load;
		logic two_curves;
		logic need_curve;
		logic curve_done;  // value settled early (special case)
		logic found;
		logic search_end;
		logic div_done;
	} dp_sts_t;

endpackage

/* rtl/hkce_ctrl.sv */
// Controller state machine of the curve evaluator.
// Depends on hkce_pkg.
module hkce_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  hkce_pkg::dp_sts_t sts,
	output hkce_pkg::dp_cmd_t cmd,
	output logic             busy,
	output logic             done
);
	import hkce_pkg::*;

	state_t state_q, state_d;
	logic   hi_q, hi_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hi_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			hi_q    <= hi_d;
		end
	end

	always_comb begin
		state_d = state_q;
		hi_d    = hi_q;
		unique case (state_q)
			ST_IDLE: begin
				hi_d = 1'b0;
				if (start) state_d = ST_CURVE;
			end
			ST_CURVE: begin
				if (sts.is_load) state_d = ST_IDLE;
				else if (sts.need_curve) state_d = ST_RD;
				else state_d = ST_BL1;
			end
			ST_RD:   state_d = ST_CHK;
			ST_CHK:  state_d = sts.curve_done ? ST_CDONE : ST_SRCH;
			ST_SRCH: begin
				if (sts.found) state_d = ST_SEG;
				else if (sts.search_end) state_d = ST_CDONE;
			end
			ST_SEG:  state_d = sts.curve_done ? ST_CDONE : ST_DIV;
			ST_DIV:  if (sts.div_done) state_d = ST_M1;
			ST_M1:   state_d = ST_M2;
			ST_M2:   state_d = ST_M3;
			ST_M3:   state_d = ST_M4;
			ST_M4:   state_d = ST_M5;
			ST_M5:   state_d = ST_M6;
			ST_M6:   state_d = ST_M7;
			ST_M7:   state_d = ST_M8;
			ST_M8:   state_d = ST_SUM;
			ST_SUM:  state_d = ST_CDONE;
			ST_CDONE: begin
				if (sts.two_curves && !hi_q) begin
					hi_d    = 1'b1;
					state_d = ST_RD;
				end else state_d = ST_BL1;
			end
			ST_BL1:  state_d = ST_BL2;
			ST_BL2:  state_d = ST_SC1;
			ST_SC1:  state_d = ST_SC2;
			ST_SC2:  state_d = ST_OUT;
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.slot_hi = hi_q;
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_OUT);
		unique case (state_q)
			ST_IDLE:  cmd.op = start ? OP_LATCH : OP_NONE;
			ST_CURVE: cmd.op = OP_CURVE;
			ST_RD:    cmd.op = OP_RD;
			ST_CHK:   cmd.op = OP_CHK;
			ST_SRCH:  cmd.op = OP_SRCH;
			ST_SEG:   cmd.op = OP_SEG;
			ST_DIV:   cmd.op = OP_DIV;
			ST_M1:    cmd.op = OP_M1;
			ST_M2:    cmd.op = OP_M2;
			ST_M3:    cmd.op = OP_M3;
			ST_M4:    cmd.op = OP_M4;
			ST_M5:    cmd.op = OP_M5;
			ST_M6:    cmd.op = OP_M6;
			ST_M7:    cmd.op = OP_M7;
			ST_M8:    cmd.op = OP_M8;
			ST_SUM:   cmd.op = OP_SUM;
			ST_CDONE: cmd.op = OP_CDONE;
			ST_BL1:   cmd.op = OP_BL1;
			ST_BL2:   cmd.op = OP_BL2;
			ST_SC1:   cmd.op = OP_SC1;
			ST_SC2:   cmd.op = OP_SC2;
			default:  cmd.op = OP_NONE;
		endcase
	end
endmodule

/* rtl/hkce_dp.sv */
// Datapath of the curve evaluator: config registers, key stores, segment
// search, serial divider, shared multiplier and output saturation. Uses hkce_pkg.
module hkce_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  hkce_pkg::in_item_t in_item,
	input  hkce_pkg::dp_cmd_t  cmd,
	output hkce_pkg::dp_sts_t  sts,
	output hkce_pkg::out_item_t out_item
);
	import hkce_pkg::*;

	// configuration
	logic [2:0]         mode_q;
	logic signed [31:0] mult_q, cval_q, clow_q, chigh_q;
	logic [CNT_W-1:0]   cnt_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_CONST;
			mult_q  <= 32'sd65536;
			cval_q  <= '0;
			clow_q  <= '0;
			chigh_q <= '0;
			for (int i = 0; i < 3; i++) cnt_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:  mode_q  <= cfg_data[2:0];
				REG_MULT:  mult_q  <= cfg_data;
				REG_CONST: cval_q  <= cfg_data;
				REG_CLOW:  clow_q  <= cfg_data;
				REG_CHIGH: chigh_q <= cfg_data;
				REG_NMAIN: cnt_q[0] <= cfg_data[CNT_W-1:0];
				REG_NLOW:  cnt_q[1] <= cfg_data[CNT_W-1:0];
				REG_NHIGH: cnt_q[2] <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// key store: one row = time, value, in slope, out slope
	typedef struct packed {
		logic [16:0]        t;
		logic signed [31:0] v;
		logic signed [31:0] si;
		logic signed [31:0] so;
	} key_t;

	key_t mem [DEPTH];
	key_t rd_q;
	logic [ADDR_W-1:0] raddr;

	// item registers
	in_item_t item_q;
	logic [16:0] t_q, w_q;

	// curve working registers
	logic [KEY_W:0]    n_q;        // clamped key count
	logic [KEY_W:0]    idx_q;      // search index
	logic [ADDR_W-1:0] base_q;
	logic [16:0]       ta_q;       // time of key a in search
	key_t              ka_q;       // key a of found segment
	logic              phase_q;    // 0: check last key, fetch key 1; 1: search pair
	logic signed [63:0] val_q;     // curve value before saturation
	logic signed [31:0] lo_q, hi_q;
	logic              sat_q;
	logic [16:0]       dt_q;
	// divider
	logic [33:0]       num_q;
	logic [16:0]       quo_q;
	logic [17:0]       rem_q;
	logic [5:0]        dcnt_q;
	// multiply chain
	logic signed [63:0] acc_q, p_q;
	logic [33:0]       t2_q, t3_q;
	logic signed [33:0] m0_q, m1_q;
	logic signed [31:0] v_q;       // selected value before scale
	logic signed [31:0] res_q;
	logic              osat_q;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x,
	                                             output logic f);
		f = 1'b0;
		if (x > 64'sd2147483647) begin f = 1'b1; return 32'sh7fffffff; end
		if (x < -64'sd2147483648) begin f = 1'b1; return 32'sh80000000; end
		return x[31:0];
	endfunction

	logic [KEY_W:0] ncl;
	logic [1:0]     cur_slot;
	always_comb begin
		cur_slot = (mode_q == MODE_CURVE) ? 2'd0 : (cmd.slot_hi ? 2'd2 : 2'd1);
		ncl = (cnt_q[cur_slot] > CNT_W'(MAX_KEYS)) ? (KEY_W+1)'(MAX_KEYS)
		      : (KEY_W+1)'(cnt_q[cur_slot]);
	end

	// read address: point at the key the next step needs, so that rd_q holds it
	// in the next cycle; hold key b of a found segment until the sum is formed
	always_comb begin
		unique case (cmd.op)
			OP_RD:   raddr = ADDR_W'(cur_slot) * ADDR_W'(MAX_KEYS);
			OP_CHK:  raddr = (n_q == '0) ? base_q : base_q + ADDR_W'(n_q - 1'b1);
			OP_SRCH: begin
				if (!phase_q) raddr = base_q + ADDR_W'(1);
				else if (sts.found || idx_q + 1'b1 >= n_q) raddr = base_q + ADDR_W'(idx_q);
				else raddr = base_q + ADDR_W'(idx_q + 1'b1);
			end
			default: raddr = base_q + ADDR_W'(idx_q);
		endcase
	end

	wire load_ok = (item_q.curve_slot != 2'd3) &&
	               ({1'b0, item_q.key_index} < 4'(MAX_KEYS));

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CURVE && item_q.cmd == CMD_LOAD && load_ok)
			mem[ADDR_W'(item_q.curve_slot) * ADDR_W'(MAX_KEYS) +
			    ADDR_W'(item_q.key_index)] <= '{item_q.key_time, item_q.key_value,
			                                   item_q.tangent_in, item_q.tangent_out};
		rd_q <= mem[raddr];
	end

	logic signed [63:0] prod;
	logic signed [33:0] ma;
	logic signed [33:0] mb;
	assign prod = 64'(ma) * 64'(mb);

	logic [17:0] rem_sh;
	assign rem_sh = {rem_q[16:0], num_q[33]};

	logic f1, f2;
	logic signed [31:0] s1, s2;
	logic signed [33:0] h00, h10, h01, h11;
	logic signed [17:0] one_w;

	always_comb begin
		ma = '0;
		mb = '0;
		h00 = 34'sd2 * $signed({1'b0, t3_q[32:0]}) - 34'sd3 * $signed({1'b0, t2_q[32:0]})
		      + 34'(ONE_Q);
		h10 = $signed(t3_q) - 34'sd2 * $signed(t2_q) + 34'($signed({1'b0, quo_q}));
		h01 = -34'sd2 * $signed(t3_q) + 34'sd3 * $signed(t2_q);
		h11 = $signed(t3_q) - $signed(t2_q);
		one_w = $signed({1'b0, ONE_Q}) - $signed({1'b0, w_q});
		unique case (cmd.op)
			OP_M1: begin ma = 34'($signed({1'b0, quo_q})); mb = 34'($signed({1'b0, quo_q})); end
			OP_M2: begin ma = 34'($signed(t2_q)); mb = 34'($signed({1'b0, quo_q})); end
			OP_M3: begin ma = 34'(ka_q.so); mb = 34'($signed({1'b0, dt_q})); end
			OP_M4: begin ma = 34'(rd_q.si); mb = 34'($signed({1'b0, dt_q})); end
			OP_M5: begin ma = h00; mb = 34'(ka_q.v); end
			OP_M6: begin ma = h01; mb = 34'(rd_q.v); end
			OP_M7: begin ma = h10; mb = m0_q; end
			OP_M8: begin ma = h11; mb = m1_q; end
			OP_BL1: begin
				ma = (mode_q == MODE_RCONST) ? 34'(clow_q) : 34'(lo_q);
				mb = 34'(one_w);
			end
			OP_BL2: begin
				ma = (mode_q == MODE_RCONST) ? 34'(chigh_q) : 34'(hi_q);
				mb = 34'($signed({1'b0, w_q}));
			end
			OP_SC1: begin ma = 34'(v_q); mb = 34'(mult_q); end
			default: ;
		endcase
		s1 = sat32(val_q, f1);
		s2 = sat32(p_q >>> FRAC_BITS, f2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q  <= '0;
			t_q     <= '0;
			w_q     <= '0;
			n_q     <= '0;
			idx_q   <= '0;
			base_q  <= '0;
			ta_q    <= '0;
			ka_q    <= '0;
			phase_q <= 1'b0;
			val_q   <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			sat_q   <= 1'b0;
			dt_q    <= '0;
			num_q   <= '0;
			quo_q   <= '0;
			rem_q   <= '0;
			dcnt_q  <= '0;
			acc_q   <= '0;
			p_q     <= '0;
			t2_q    <= '0;
			t3_q    <= '0;
			m0_q    <= '0;
			m1_q    <= '0;
			v_q     <= '0;
			res_q   <= '0;
			osat_q  <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_LATCH: begin
					item_q <= in_item;
					t_q <= (in_item.sample_time > ONE_Q) ? ONE_Q : in_item.sample_time;
					w_q <= (in_item.random_weight > ONE_Q) ? ONE_Q : in_item.random_weight;
					sat_q <= 1'b0;
				end
				OP_CURVE: ;
				OP_RD: begin
					n_q     <= ncl;
					base_q  <= ADDR_W'(cur_slot) * ADDR_W'(MAX_KEYS);
					idx_q   <= '0;
					phase_q <= 1'b0;
				end
				OP_CHK: begin
					// rd_q holds key 0 here
					if (n_q == '0) val_q <= '0;
					else val_q <= 64'(rd_q.v);
					ta_q  <= rd_q.t;
					ka_q  <= rd_q;
					phase_q <= 1'b0;
				end
				OP_SRCH: begin
					if (!phase_q) begin
						// rd_q holds the last key
						phase_q <= 1'b1;
						idx_q   <= (KEY_W+1)'(1);
						if (t_q >= rd_q.t) val_q <= 64'(rd_q.v);
					end else if (!sts.found) begin
						// advance to the next pair; hold the index at the last key
						ka_q <= rd_q;
						ta_q <= rd_q.t;
						if (idx_q + 1'b1 >= n_q) val_q <= 64'(rd_q.v);
						else idx_q <= idx_q + 1'b1;
					end
				end
				OP_SEG: begin
					dt_q <= rd_q.t - ka_q.t;
					val_q <= 64'(ka_q.v);
					num_q <= {t_q - ka_q.t, 17'd0} >> 1;
					rem_q <= '0;
					quo_q <= '0;
					dcnt_q <= 6'd34;
				end
				OP_DIV: begin
					if (rem_sh >= {1'b0, dt_q}) begin
						rem_q <= rem_sh - {1'b0, dt_q};
						quo_q <= {quo_q[15:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[15:0], 1'b0};
					end
					num_q  <= {num_q[32:0], 1'b0};
					dcnt_q <= dcnt_q - 1'b1;
				end
				OP_M1: t2_q <= 34'(prod >>> FRAC_BITS);
				OP_M2: t3_q <= 34'(prod >>> FRAC_BITS);
				OP_M3: m0_q <= 34'(prod >>> FRAC_BITS);
				OP_M4: m1_q <= 34'(prod >>> FRAC_BITS);
				OP_M5: acc_q <= prod;
				OP_M6: acc_q <= acc_q + prod;
				OP_M7: acc_q <= acc_q + prod;
				OP_M8: acc_q <= acc_q + prod;
				OP_SUM: val_q <= acc_q >>> FRAC_BITS;
				OP_CDONE: begin
					if (f1) sat_q <= 1'b1;
					if (cmd.slot_hi || mode_q == MODE_CURVE) hi_q <= s1;
					else lo_q <= s1;
				end
				OP_BL1: p_q <= prod;
				OP_BL2: begin
					unique case (mode_q)
						MODE_CONST, MODE_TWOC: v_q <= cval_q;
						MODE_CURVE: v_q <= hi_q;
						MODE_TWOCV, MODE_RCURVE, MODE_RCONST:
							v_q <= 32'((p_q + prod) >>> FRAC_BITS);
						default: v_q <= '0;
					endcase
				end
				OP_SC1: p_q <= prod;
				OP_SC2: begin
					res_q  <= s2;
					osat_q <= sat_q | f2;
				end
				default: ;
			endcase
		end
	end

	// status for the controller; the divider ends on the last of its 34 steps
	always_comb begin
		sts.is_load    = (item_q.cmd == CMD_LOAD);
		sts.two_curves = (mode_q == MODE_TWOCV) || (mode_q == MODE_RCURVE);
		sts.need_curve = sts.two_curves || (mode_q == MODE_CURVE);
		sts.curve_done = 1'b0;
		if (cmd.op == OP_CHK)
			sts.curve_done = (n_q < (KEY_W+1)'(2)) || (t_q <= rd_q.t);
		else if (cmd.op == OP_SEG)
			sts.curve_done = (34'(rd_q.t - ka_q.t) * 34'd10000 < 34'(ONE_Q));
		sts.found      = (cmd.op == OP_SRCH) && phase_q && (t_q >= ta_q) && (t_q <= rd_q.t);
		sts.search_end = (cmd.op == OP_SRCH) &&
		                 ((!phase_q && t_q >= rd_q.t) ||
		                  (phase_q && idx_q + 1'b1 >= n_q));
		sts.div_done   = (dcnt_q == 6'd1);
		out_item.curve_result = res_q;
		out_item.saturated    = osat_q;
	end
endmodule

/* rtl/hermite_keyframe_curve_eval_core.sv */
// Top level of the Hermite keyframe curve evaluator.
// Depends on hkce_pkg, hkce_ctrl and hkce_dp.
//
//  channel   handshake           payload
//  input     start & !busy       in_item  (hkce_pkg::in_item_t)
//  result    done, one cycle     out_item (hkce_pkg::out_item_t)
//  config    cfg_we              cfg_index, cfg_data
//
// A load holds busy for one cycle after its transfer. An evaluation raises done
// once curve work, blend and scale are through: none for the constant modes, one
// curve for the one-curve mode and two in turn for the two-curve modes; the serial
// divider (one quotient bit a cycle, 34 steps) and the linear segment search set
// how long the curve work takes. Busy stays high until the cycle after done.
// Reset clears control and configuration; key stores hold nothing until loaded.
// The receiver cannot stall: each result transfer lasts exactly one cycle.
module hermite_keyframe_curve_eval_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  hkce_pkg::in_item_t  in_item,
	output logic                busy,
	output logic                done,
	output hkce_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import hkce_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequence each item through the datapath
	hkce_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts),
		.cmd(cmd), .busy(busy), .done(done)
	);

	// hold configuration and key stores, compute results
	hkce_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_item(in_item), .cmd(cmd), .sts(sts),
		.out_item(out_item)
	);
endmodule

/* bench/testbench.sv */
// Self-checking bench for hermite_keyframe_curve_eval_core: key loads, curve evaluations
// and register phases, with a local Hermite predictor. Depends on hkce_pkg and the core.
module testbench;
	import hkce_pkg::*;

	localparam int SETTLE_CYCLES = 150;
	localparam int STALL_LIMIT   = 3000;

	logic        clk;
	logic        arst_n;
	logic        start;
	in_item_t    in_item;
	logic        busy;
	logic        done;
	out_item_t   out_item;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	hermite_keyframe_curve_eval_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .in_item(in_item), .busy(busy),
		.done(done), .out_item(out_item), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor copy of configuration and key stores
	logic [2:0] mdl_mode = MODE_CONST;
	longint     mdl_mult = 65536;
	longint     mdl_const = 0;
	longint     mdl_clow = 0;
	longint     mdl_chigh = 0;
	int         mdl_count [3] = '{0, 0, 0};
	longint     key_t [DEPTH];
	longint     key_v [DEPTH];
	longint     key_si [DEPTH];
	longint     key_so [DEPTH];

	in_item_t   pending_items [$];
	out_item_t  expected_results [$];
	int         mismatches = 0;
	int         stall_cycles = 0;
	bit         took = 0;
	bit         burst = 0;
	int         gap = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
		mismatches++;
	endtask

	function automatic longint clip32(input longint x, inout bit flag);
		if (x > 64'sd2147483647) begin
			flag = 1;
			return 64'sd2147483647;
		end
		if (x < -64'sd2147483648) begin
			flag = 1;
			return -64'sd2147483648;
		end
		return x;
	endfunction

	function automatic longint hermite_value(input int slot, input longint t);
		int n, b;
		longint dt, u, t2, t3, h00, h10, h01, h11, m0, m1, acc;
		n = (mdl_count[slot] > MAX_KEYS) ? MAX_KEYS : mdl_count[slot];
		b = slot * MAX_KEYS;
		if (n == 0) return 0;
		if (n == 1 || t <= key_t[b]) return key_v[b];
		if (t >= key_t[b+n-1]) return key_v[b+n-1];
		for (int i = b; i < b + n - 1; i++) begin
			if (t >= key_t[i] && t <= key_t[i+1]) begin
				dt = key_t[i+1] - key_t[i];
				if (dt * 10000 < 65536) return key_v[i];
				u   = ((t - key_t[i]) << FRAC_BITS) / dt;
				t2  = (u * u) >>> FRAC_BITS;
				t3  = (t2 * u) >>> FRAC_BITS;
				h00 = 2 * t3 - 3 * t2 + 65536;
				h10 = t3 - 2 * t2 + u;
				h01 = -2 * t3 + 3 * t2;
				h11 = t3 - t2;
				m0  = (key_so[i] * dt) >>> FRAC_BITS;
				m1  = (key_si[i+1] * dt) >>> FRAC_BITS;
				acc = h00 * key_v[i] + h10 * m0 + h01 * key_v[i+1] + h11 * m1;
				return acc >>> FRAC_BITS;
			end
		end
		return key_v[b+n-1];
	endfunction

	function automatic longint mix(input longint lo, input longint hi, input longint w);
		return (lo * (65536 - w) + hi * w) >>> FRAC_BITS;
	endfunction

	function automatic out_item_t predict_result(input in_item_t it);
		out_item_t r;
		bit        flag;
		longint    t, w, v, lo, hi;
		flag = 0;
		t = longint'(it.sample_time);
		w = longint'(it.random_weight);
		if (t > 65536) t = 65536;
		if (w > 65536) w = 65536;
		case (mdl_mode)
			MODE_CONST, MODE_TWOC: v = mdl_const;
			MODE_CURVE:            v = clip32(hermite_value(0, t), flag);
			MODE_TWOCV, MODE_RCURVE: begin
				lo = clip32(hermite_value(1, t), flag);
				hi = clip32(hermite_value(2, t), flag);
				v  = mix(lo, hi, w);
			end
			MODE_RCONST:           v = mix(mdl_clow, mdl_chigh, w);
			default:               v = 0;
		endcase
		r.curve_result = 32'(clip32((v * mdl_mult) >>> FRAC_BITS, flag));
		r.saturated    = flag;
		return r;
	endfunction

	// driver: present queued items at the falling edge, hold until transfer
	always @(negedge clk) begin
		if (!(start && !took)) begin
			if (gap > 0) begin
				start <= 0;
				gap   <= gap - 1;
			end else if (pending_items.size() > 0) begin
				in_item <= pending_items.pop_front();
				start   <= 1;
				gap     <= burst ? 0 : $urandom_range(0, 6);
			end else begin
				start <= 0;
			end
		end
	end

	// monitor: track transfers, update predictor, check results
	always @(posedge clk) begin
		out_item_t want;
		int        e;
		took = start && !busy && arst_n;
		if (cfg_we) begin
			case (cfg_index)
				REG_MODE:  mdl_mode = cfg_data[2:0];
				REG_MULT:  mdl_mult = longint'($signed(cfg_data));
				REG_CONST: mdl_const = longint'($signed(cfg_data));
				REG_CLOW:  mdl_clow = longint'($signed(cfg_data));
				REG_CHIGH: mdl_chigh = longint'($signed(cfg_data));
				REG_NMAIN: mdl_count[0] = cfg_data[3:0];
				REG_NLOW:  mdl_count[1] = cfg_data[3:0];
				REG_NHIGH: mdl_count[2] = cfg_data[3:0];
				default: ;
			endcase
		end
		if (done) begin
			if (expected_results.size() == 0) begin
				report("unexpected result", longint'($signed(out_item.curve_result)), 0);
			end else begin
				want = expected_results.pop_front();
				if (out_item.curve_result !== want.curve_result)
					report("curve_result", longint'($signed(out_item.curve_result)),
						longint'($signed(want.curve_result)));
				if (out_item.saturated !== want.saturated)
					report("saturated", out_item.saturated, want.saturated);
			end
		end
		if (took) begin
			if (in_item.cmd == CMD_LOAD) begin
				// drop loads aimed at the unused slot
				if (in_item.curve_slot <= 2) begin
					e = in_item.curve_slot * MAX_KEYS + in_item.key_index;
					key_t[e]  = longint'(in_item.key_time);
					key_v[e]  = longint'($signed(in_item.key_value));
					key_si[e] = longint'($signed(in_item.tangent_in));
					key_so[e] = longint'($signed(in_item.tangent_out));
				end
			end else begin
				expected_results.push_back(predict_result(in_item));
			end
		end
		// watchdog: only count while work is outstanding
		if (took || done || cfg_we || (pending_items.size() == 0 && !start
				&& expected_results.size() == 0))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic write_all(input logic [2:0] mode, input logic [31:0] mult,
			input logic [31:0] cv, input logic [31:0] lo, input logic [31:0] hi,
			input logic [3:0] nm, input logic [3:0] nl, input logic [3:0] nh);
		write_reg(REG_MODE, mode);
		write_reg(REG_MULT, mult);
		write_reg(REG_CONST, cv);
		write_reg(REG_CLOW, lo);
		write_reg(REG_CHIGH, hi);
		write_reg(REG_NMAIN, nm);
		write_reg(REG_NLOW, nl);
		write_reg(REG_NHIGH, nh);
	endtask

	task automatic push_key(input logic [1:0] slot, input logic [2:0] idx,
			input logic [16:0] kt, input logic [31:0] kv, input logic [31:0] ti,
			input logic [31:0] to);
		in_item_t it;
		it = '0;
		it.cmd = CMD_LOAD;
		it.curve_slot = slot;
		it.key_index = idx;
		it.key_time = kt;
		it.key_value = kv;
		it.tangent_in = ti;
		it.tangent_out = to;
		it.sample_time = $urandom;
		it.random_weight = $urandom;
		pending_items.push_back(it);
	endtask

	task automatic push_eval(input logic [16:0] t, input logic [16:0] w);
		in_item_t it;
		it = '0;
		it.cmd = CMD_EVAL;
		it.sample_time = t;
		it.random_weight = w;
		it.curve_slot = $urandom;
		it.key_index = $urandom;
		it.key_time = $urandom;
		it.key_value = $urandom;
		it.tangent_in = $urandom;
		it.tangent_out = $urandom;
		pending_items.push_back(it);
	endtask

	// wait for the queue and all expected results, then let loads finish
	task automatic settle();
		while (pending_items.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0:       return $urandom;
			1:       return 32'h7fffffff;
			2:       return 32'h80000000;
			default: return $urandom_range(0, 8 << 16) - (4 << 16);
		endcase
	endfunction

	function automatic logic [16:0] pick_time();
		case ($urandom_range(0, 9))
			0:       return $urandom;
			1:       return 0;
			2:       return ONE_Q;
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	// reload a whole curve, usually with sorted times
	task automatic reload_curve(input logic [1:0] slot);
		int t;
		bit scramble;
		t = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 20000);
		scramble = $urandom_range(0, 9) == 0;
		for (int i = 0; i < MAX_KEYS; i++) begin
			push_key(slot, i, scramble ? pick_time() : 17'(t), pick_value(),
				pick_value(), pick_value());
			t += $urandom_range(0, 4) == 0 ? $urandom_range(0, 6) : $urandom_range(0, 20000);
			if (t > 131071) t = 131071;
		end
	endtask

	initial begin
		arst_n    = 0;
		start     = 0;
		in_item   = '0;
		cfg_we    = 0;
		cfg_index = REG_MODE;
		cfg_data  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: fill every key so no evaluation reads an empty entry;
		// the main curve holds a short segment between keys 1 and 2
		burst = 1;
		for (int s = 0; s < 3; s++)
			for (int i = 0; i < MAX_KEYS; i++)
				push_key(s, i, 17'(i * 9000 + 1000), 32'((i + 1 + s) << 16),
					32'(-i << 15), 32'(i << 14));
		push_key(0, 2, 17'd10003, 32'h00030000, 0, 0);
		push_key(3, 5, 17'd5, 32'h7fffffff, 0, 0);
		settle();
		write_all(MODE_CURVE, 32'h00010000, 0, 0, 0, 4'd0, 4'd8, 4'd8);
		push_eval(17'd30000, 0);
		settle();
		write_reg(REG_NMAIN, 4'd1);
		push_eval(17'd50000, 0);
		settle();
		write_reg(REG_NMAIN, 4'd15);
		push_eval(0, 0);
		push_eval(17'd1000, 0);
		push_eval(17'd10001, 0);
		push_eval(17'd40000, 0);
		push_eval(17'h1ffff, 17'h1ffff);
		push_eval(ONE_Q, 0);
		settle();
		// curve overflow through huge tangents, and unsorted keys
		push_key(1, 3, 17'd28000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		push_key(1, 4, 17'd2000, 32'h80000000, 32'h80000000, 32'h7fffffff);
		settle();
		write_all(MODE_RCURVE, 32'h80000000, 0, 0, 0, 4'd8, 4'd8, 4'd8);
		push_eval(17'd25000, 17'h1ffff);
		push_eval(17'd20000, 17'd32768);
		settle();
		write_all(MODE_RCONST, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			4'd8, 4'd8, 4'd8);
		push_eval(0, 0);
		push_eval(0, ONE_Q);
		push_eval(0, 17'd12345);
		settle();
		write_reg(REG_MODE, 3'd6);
		push_eval(17'd100, 17'd100);
		settle();
		write_reg(REG_MODE, 3'd7);
		write_reg(REG_MULT, 32'h80000000);
		write_reg(REG_CONST, 32'h80000000);
		push_eval(17'd100, 17'd100);
		settle();
		write_all(MODE_TWOC, 32'h80000000, 32'h80000000, 0, 0, 4'd2, 4'd2, 4'd2);
		push_eval(0, 0);
		settle();
		write_reg(REG_MODE, MODE_CONST);
		write_reg(REG_MULT, 32'h7fffffff);
		write_reg(REG_CONST, 32'h7fffffff);
		push_eval(0, 0);
		settle();

		// random phases: mostly evaluations, with whole-curve reloads
		for (int p = 0; p < 12; p++) begin
			burst = $urandom_range(0, 3) == 0;
			write_all($urandom_range(0, 7),
				$urandom_range(0, 3) == 0 ? pick_value() : $urandom_range(0, 1 << 17) - 65536,
				pick_value(), pick_value(), pick_value(),
				$urandom_range(0, 5) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 8),
				$urandom_range(0, 5) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 8),
				$urandom_range(0, 5) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 8));
			for (int k = 0; k < 6; k++) begin
				if ($urandom_range(0, 1) == 0)
					reload_curve($urandom_range(0, 2));
				if ($urandom_range(0, 7) == 0)
					push_key(3, $urandom, $urandom, $urandom, $urandom, $urandom);
				for (int j = 0; j < 8; j++)
					push_eval(pick_time(), pick_time());
			end
			settle();
		end

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
